// ----- hw/rtl/q4sj_pkg.sv -----
// Package: shared widths and constants for the quad4 shape/Jacobian block.
`timescale 1ns / 1ps
package q4sj_pkg;
  localparam int COORD_FRAC_BITS_DEF = 16;
  localparam int NAT_W = 18;
  localparam int CRD_W = 32;
  localparam int DET_W = 64;
  localparam int QUO_W = 34;
  localparam logic [31:0] NAT_ONE = 32'd65536;
endpackage

// ----- hw/rtl/q4sj_div.sv -----
// Pipelined restoring divider: one quotient bit per stage, rounded and saturated to 32 bits.
`timescale 1ns / 1ps
module q4sj_div import q4sj_pkg::*; #(
  parameter int FRAC = COORD_FRAC_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [CRD_W:0]   num,
  input  logic signed [DET_W-1:0] den,
  output logic signed [CRD_W-1:0] quo
);
  localparam int NB = 2 * FRAC + CRD_W + 1;
  localparam int ST = QUO_W;
  localparam int RW = DET_W + 1;

  logic [NB-1:0] dvd_r [ST+1];
  logic [RW-1:0] rem_r [ST+1];
  logic [ST-1:0] q_r   [ST+1];
  logic [DET_W-1:0] dm_r [ST+1];
  logic          neg_r [ST+1];
  logic          big_r [ST+1];
  logic [CRD_W:0] nm;
  logic [DET_W-1:0] dmag;
  logic [NB-1:0] dvd0;
  logic [RW-1:0] top0;
  logic [ST:0]   qr;
  logic          up;

  assign nm = num[CRD_W] ? (CRD_W+1)'(-num) : num;
  assign dmag = den[DET_W-1] ? DET_W'(-den) : den;
  assign dvd0 = NB'(nm) << (2 * FRAC);
  assign top0 = RW'(dvd0 >> ST);

  // Flag a quotient too wide for the window: leading bits not below the divisor.
  always_ff @(posedge clk) begin
    if (en) begin
      dvd_r[0] <= dvd0;
      rem_r[0] <= top0;
      q_r[0]   <= '0;
      dm_r[0]  <= dmag;
      neg_r[0] <= num[CRD_W] ^ den[DET_W-1];
      big_r[0] <= top0 >= {1'b0, dmag};
    end
  end

  for (genvar i = 0; i < ST; i++) begin : g_st
    logic [RW-1:0] rw;
    logic          ge;
    logic [RW-1:0] rs;
    always_comb begin
      rw = {rem_r[i][RW-2:0], dvd_r[i][ST-1-i]};
      ge = rw >= {1'b0, dm_r[i]};
      rs = ge ? rw - {1'b0, dm_r[i]} : rw;
    end
    always_ff @(posedge clk) begin
      if (en) begin
        dvd_r[i+1] <= dvd_r[i];
        rem_r[i+1] <= rs;
        q_r[i+1]   <= {q_r[i][ST-2:0], ge};
        dm_r[i+1]  <= dm_r[i];
        neg_r[i+1] <= neg_r[i];
        big_r[i+1] <= big_r[i];
      end
    end
  end

  // Rounding.
  logic [ST:0]   qf;
  always_comb begin
    qf  = {1'b0, q_r[ST]};
    up  = rem_r[ST] >= ({1'b0, dm_r[ST]} - rem_r[ST]);
    qr  = qf + (ST+1)'(up);
  end

  logic [ST:0] qs;
  always_comb begin
    qs = (big_r[ST] || qf > (ST+1)'(33'h100000000)) ? (ST+1)'(33'h100000000) : qr;
    if (neg_r[ST]) quo = (qs > (ST+1)'(32'h80000000)) ? 32'sh80000000 : CRD_W'(-qs);
    else           quo = (qs > (ST+1)'(32'h7FFFFFFF)) ? 32'sh7FFFFFFF : CRD_W'(qs);
  end
endmodule

// ----- hw/rtl/quad4_shape_jacobian.sv -----
// Quad4 shape functions and Jacobian: 42 register stages (Jacobian, det, divider, node serializer).
// Each input item yields four result items, one per cycle while out_tready does not stall the output.
// The divider's setup stage and 34 one-bit stages set the latency; the single result channel sets the rate.
// Reset: rst_n synchronous active low clears valid bits, the node counter and the input pace counter.
`timescale 1ns / 1ps
module quad4_shape_jacobian import q4sj_pkg::*; #(
  parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // nat_r, nat_s, corner0_x..corner3_x, corner0_y..corner3_y, 4 zero bits
  input  logic [295:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic         out_tlast,
  // node_index, shape_value, deriv_x, deriv_y, jacobian_det, inv_jac_00/01/10/11, singular, 4 zero
  output logic [279:0] out_tdata
);
  localparam int DL = QUO_W + 1;
  localparam int F = COORD_FRAC_BITS;

  logic en;
  logic signed [NAT_W-1:0] r_in, s_in;
  logic signed [CRD_W-1:0] cx [4];
  logic signed [CRD_W-1:0] cy [4];
  assign r_in = in_tdata[17:0];
  assign s_in = in_tdata[35:18];
  for (genvar k = 0; k < 4; k++) begin : g_in
    assign cx[k] = in_tdata[36+32*k +: 32];
    assign cy[k] = in_tdata[164+32*k +: 32];
  end

  // Stage 1: products of corners with natural derivative factors.
  logic signed [19:0] pr [4];
  logic signed [19:0] ps [4];
  always_comb begin
    pr[0] = 20'sd65536 - r_in; pr[1] = 20'sd65536 + r_in;
    pr[2] = 20'sd65536 + r_in; pr[3] = 20'sd65536 - r_in;
    ps[0] = 20'sd65536 - s_in; ps[1] = 20'sd65536 - s_in;
    ps[2] = 20'sd65536 + s_in; ps[3] = 20'sd65536 + s_in;
  end
  logic signed [52:0] m00_r [4], m01_r [4], m10_r [4], m11_r [4];
  logic signed [19:0] pr1_r [4], ps1_r [4];
  logic v1_r;
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        m00_r[k] <= cx[k] * ((k == 0 || k == 3) ? -ps[k] : ps[k]);
        m01_r[k] <= cx[k] * ((k < 2) ? -pr[k] : pr[k]);
        m10_r[k] <= cy[k] * ((k == 0 || k == 3) ? -ps[k] : ps[k]);
        m11_r[k] <= cy[k] * ((k < 2) ? -pr[k] : pr[k]);
        pr1_r[k] <= pr[k];
        ps1_r[k] <= ps[k];
      end
    end
  end

  // Stage 2: sum, round, saturate Jacobian entries.
  function automatic logic signed [CRD_W-1:0] rsat(input logic signed [55:0] a);
    logic signed [55:0] t;
    t = (a + 56'sd131072) >>> 18;
    if (t > 56'sd2147483647) return 32'sh7FFFFFFF;
    if (t < -56'sd2147483648) return 32'sh80000000;
    return CRD_W'(t);
  endfunction
  function automatic logic signed [55:0] sum4(input logic signed [52:0] a0, input logic signed [52:0] a1,
                                              input logic signed [52:0] a2, input logic signed [52:0] a3);
    return 56'(a0) + 56'(a1) + 56'(a2) + 56'(a3);
  endfunction
  logic signed [CRD_W-1:0] j00_r, j01_r, j10_r, j11_r;
  logic signed [19:0] pr2_r [4], ps2_r [4];
  logic v2_r;
  always_ff @(posedge clk) begin
    if (en) begin
      j00_r <= rsat(sum4(m00_r[0], m00_r[1], m00_r[2], m00_r[3]));
      j01_r <= rsat(sum4(m01_r[0], m01_r[1], m01_r[2], m01_r[3]));
      j10_r <= rsat(sum4(m10_r[0], m10_r[1], m10_r[2], m10_r[3]));
      j11_r <= rsat(sum4(m11_r[0], m11_r[1], m11_r[2], m11_r[3]));
      pr2_r <= pr1_r;
      ps2_r <= ps1_r;
    end
  end

  // Stage 3: determinant products; stage 4: subtract.
  logic signed [63:0] pa_r, pb_r;
  logic signed [CRD_W-1:0] j3_r [4];
  logic signed [19:0] pr3_r [4], ps3_r [4];
  logic v3_r;
  always_ff @(posedge clk) begin
    if (en) begin
      pa_r <= j00_r * j11_r;
      pb_r <= j01_r * j10_r;
      j3_r[0] <= j00_r; j3_r[1] <= j01_r; j3_r[2] <= j10_r; j3_r[3] <= j11_r;
      pr3_r <= pr2_r;
      ps3_r <= ps2_r;
    end
  end
  logic signed [DET_W-1:0] det_r;
  logic signed [CRD_W-1:0] j4_r [4];
  logic signed [19:0] pr4_r [4], ps4_r [4];
  logic v4_r;
  always_ff @(posedge clk) begin
    if (en) begin
      det_r <= pa_r - pb_r;
      j4_r  <= j3_r;
      pr4_r <= pr3_r;
      ps4_r <= ps3_r;
    end
  end

  // Dividers for the four inverse entries.
  logic signed [CRD_W-1:0] iq [4];
  logic signed [CRD_W:0] nums [4];
  assign nums[0] = {j4_r[3][CRD_W-1], j4_r[3]};
  assign nums[1] = -{j4_r[1][CRD_W-1], j4_r[1]};
  assign nums[2] = -{j4_r[2][CRD_W-1], j4_r[2]};
  assign nums[3] = {j4_r[0][CRD_W-1], j4_r[0]};
  for (genvar k = 0; k < 4; k++) begin : g_div
    q4sj_div #(.FRAC(F)) u_div (
      .clk(clk), .en(en), .num(nums[k]), .den(det_r), .quo(iq[k])
    );
  end
  logic [DL-1:0] vd_r;
  logic signed [DET_W-1:0] detd_r [DL];
  logic signed [19:0] prd_r [DL][4];
  logic signed [19:0] psd_r [DL][4];
  always_ff @(posedge clk) begin
    if (en) begin
      detd_r[0] <= det_r;
      prd_r[0]  <= pr4_r;
      psd_r[0]  <= ps4_r;
      for (int i = 1; i < DL; i++) begin
        detd_r[i] <= detd_r[i-1];
        prd_r[i]  <= prd_r[i-1];
        psd_r[i]  <= psd_r[i-1];
      end
    end
  end

  // Item holding register feeding the node serializer.
  logic signed [DET_W-1:0] hdet_r;
  logic signed [CRD_W-1:0] hi_r [4];
  logic signed [19:0] hpr_r [4], hps_r [4];
  logic hv_r;
  logic [1:0] node_r;
  logic tk;
  logic last_v;
  assign last_v = vd_r[DL-1];
  // Stall whole pipe only when a finished item has nowhere to go.
  logic hfree;
  assign hfree = !hv_r || (tk && node_r == 2'd3);
  assign en = hfree || !last_v;

  // Input pacing: after an accepted item, hold in_tready low until the pace counter wraps to zero.
  logic [1:0] pace_r;
  assign in_tready = en && pace_r == 2'd0;
  always_ff @(posedge clk) begin
    if (!rst_n) pace_r <= '0;
    else if (pace_r != 2'd0) pace_r <= pace_r + 2'd1;
    else if (in_tvalid && in_tready) pace_r <= 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0; v4_r <= 1'b0; vd_r <= '0;
    end else if (en) begin
      v1_r <= in_tvalid && in_tready;
      v2_r <= v1_r; v3_r <= v2_r; v4_r <= v3_r;
      vd_r <= {vd_r[DL-2:0], v4_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hv_r <= 1'b0;
      node_r <= '0;
    end else begin
      if (tk) node_r <= node_r + 2'd1;
      if (hfree) hv_r <= last_v && en;
    end
  end
  always_ff @(posedge clk) begin
    if (hfree && last_v) begin
      hdet_r <= detd_r[DL-1];
      hi_r   <= iq;
      hpr_r  <= prd_r[DL-1];
      hps_r  <= psd_r[DL-1];
    end
  end

  // Per-node stage: shape and derivative products.
  logic sing;
  assign sing = hdet_r == '0;
  logic signed [19:0] dr, ds;
  logic signed [39:0] shp_p;
  logic signed [52:0] px0, px1, py0, py1;
  always_comb begin
    dr = (node_r == 2'd0 || node_r == 2'd3) ? -hps_r[node_r] : hps_r[node_r];
    ds = (node_r < 2'd2) ? -hpr_r[node_r] : hpr_r[node_r];
    shp_p = hpr_r[node_r] * hps_r[node_r];
    px0 = dr * hi_r[0];
    px1 = ds * hi_r[2];
    py0 = dr * hi_r[1];
    py1 = ds * hi_r[3];
  end

  // Output register stages: products, then round and pack.
  logic sv_r, s_last_r, s_sing_r;
  logic [1:0] s_node_r;
  logic signed [39:0] s_shp_r;
  logic signed [52:0] s_px0_r, s_px1_r, s_py0_r, s_py1_r;
  logic signed [DET_W-1:0] s_det_r;
  logic signed [CRD_W-1:0] s_i_r [4];
  logic s_go;
  logic o_free;
  assign o_free = !out_tvalid || out_tready;
  assign s_go = !sv_r || o_free;
  assign tk = hv_r && s_go;

  always_ff @(posedge clk) begin
    if (!rst_n) sv_r <= 1'b0;
    else if (s_go) sv_r <= hv_r;
  end
  always_ff @(posedge clk) begin
    if (tk) begin
      s_node_r <= node_r;
      s_last_r <= node_r == 2'd3;
      s_sing_r <= sing;
      s_shp_r  <= shp_p;
      s_px0_r <= px0; s_px1_r <= px1; s_py0_r <= py0; s_py1_r <= py1;
      s_det_r <= hdet_r;
      s_i_r   <= hi_r;
    end
  end

  logic signed [39:0] shp_t;
  logic [16:0] shp_o;
  logic signed [CRD_W-1:0] dx_o, dy_o;
  always_comb begin
    shp_t = (s_shp_r + 40'sd131072) >>> 18;
    if (shp_t < 0) shp_o = '0;
    else if (shp_t > 40'sd65536) shp_o = 17'd65536;
    else shp_o = 17'(shp_t);
    dx_o = s_sing_r ? '0 : rsat(56'(s_px0_r) + 56'(s_px1_r));
    dy_o = s_sing_r ? '0 : rsat(56'(s_py0_r) + 56'(s_py1_r));
  end

  logic [279:0] od_r;
  logic ol_r, ov_r;
  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= 1'b0;
    else if (o_free) ov_r <= sv_r;
  end
  always_ff @(posedge clk) begin
    if (o_free && sv_r) begin
      ol_r <= s_last_r;
      od_r <= {4'b0, s_sing_r,
               s_sing_r ? 32'd0 : s_i_r[3], s_sing_r ? 32'd0 : s_i_r[2],
               s_sing_r ? 32'd0 : s_i_r[1], s_sing_r ? 32'd0 : s_i_r[0],
               s_det_r, dy_o, dx_o, shp_o, s_node_r};
    end
  end
  assign out_tvalid = ov_r;
  assign out_tlast  = ol_r;
  assign out_tdata  = od_r;

`ifndef NO_ASSERTIONS
  a_last_node: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tlast == (out_tdata[1:0] == 2'd3)))
    else $error("tlast mismatch");
  a_sing_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[275] |-> out_tdata[146:83] == 64'd0)
    else $error("singular with nonzero det");
  a_pace: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input pacing broken");
`endif
endmodule

// ----- verif/tb_quad4_shape_jacobian.sv -----
// Testbench for quad4_shape_jacobian: directed and random stream stimulus checked against a bit-true predictor.
`timescale 1ns / 1ps
module tb_quad4_shape_jacobian;

  typedef struct packed {
    logic signed [17:0] r;
    logic signed [17:0] s;
    logic signed [3:0][31:0] cx;
    logic signed [3:0][31:0] cy;
  } point_t;

  typedef struct packed {
    logic [1:0]  node;
    logic        last;
    logic [16:0] shape;
    logic [31:0] dx;
    logic [31:0] dy;
    logic [63:0] det;
    logic [31:0] i00;
    logic [31:0] i01;
    logic [31:0] i10;
    logic [31:0] i11;
    logic        sing;
  } node_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [295:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic out_tlast;
  logic [279:0] out_tdata;

  point_t pending_pts[$];
  node_res_t expected_nodes[$];
  point_t cur_pt;
  int errors = 0;
  int in_gap = 0;
  int out_gap = 0;
  bit in_fire = 1'b0;

  quad4_shape_jacobian dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tlast(out_tlast),
    .out_tdata(out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint rshift18(longint v);
    return (v + 64'sd131072) >>> 18;
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint inverse_entry(longint num, longint det);
    logic [127:0] m, dm, q, rem;
    bit neg;
    m = (num < 0) ? 128'(-num) : 128'(num);
    dm = (det < 0) ? 128'(-det) : 128'(det);
    neg = (num < 0) != (det < 0);
    m = m << 32;
    q = m / dm;
    rem = m % dm;
    if (q > 128'h1_0000_0000) q = 128'h1_0000_0000;
    else if (rem >= dm - rem) q = q + 1;
    if (neg) return (q > 128'h8000_0000) ? -64'sd2147483648 : -longint'(q);
    return (q > 128'h7FFF_FFFF) ? 64'sd2147483647 : longint'(q);
  endfunction

  function automatic void predict_nodes(point_t p);
    longint r, s, a00, a01, a10, a11, j00, j01, j10, j11, det;
    longint i00, i01, i10, i11, dr, ds, shp, dx, dy;
    longint pr[4], ps[4];
    int sr[4], ss[4];
    bit sing;
    node_res_t n;
    sr = '{-1, 1, 1, -1};
    ss = '{-1, -1, 1, 1};
    r = p.r;
    s = p.s;
    a00 = 0; a01 = 0; a10 = 0; a11 = 0;
    i00 = 0; i01 = 0; i10 = 0; i11 = 0;
    for (int k = 0; k < 4; k++) begin
      pr[k] = 65536 + sr[k] * r;
      ps[k] = 65536 + ss[k] * s;
      a00 += longint'($signed(p.cx[k])) * (sr[k] * ps[k]);
      a01 += longint'($signed(p.cx[k])) * (ss[k] * pr[k]);
      a10 += longint'($signed(p.cy[k])) * (sr[k] * ps[k]);
      a11 += longint'($signed(p.cy[k])) * (ss[k] * pr[k]);
    end
    j00 = clamp32(rshift18(a00));
    j01 = clamp32(rshift18(a01));
    j10 = clamp32(rshift18(a10));
    j11 = clamp32(rshift18(a11));
    det = j00 * j11 - j01 * j10;
    sing = (det == 0);
    if (!sing) begin
      i00 = inverse_entry(j11, det);
      i11 = inverse_entry(j00, det);
      i01 = inverse_entry(-j01, det);
      i10 = inverse_entry(-j10, det);
    end
    for (int k = 0; k < 4; k++) begin
      dr = sr[k] * ps[k];
      ds = ss[k] * pr[k];
      shp = rshift18(pr[k] * ps[k]);
      if (shp < 0) shp = 0;
      if (shp > 65536) shp = 65536;
      dx = 0;
      dy = 0;
      if (!sing) begin
        dx = clamp32(rshift18(dr * i00 + ds * i10));
        dy = clamp32(rshift18(dr * i01 + ds * i11));
      end
      n.node = k[1:0];
      n.last = (k == 3);
      n.shape = shp[16:0];
      n.dx = dx[31:0];
      n.dy = dy[31:0];
      n.det = det;
      n.i00 = i00[31:0];
      n.i01 = i01[31:0];
      n.i10 = i10[31:0];
      n.i11 = i11[31:0];
      n.sing = sing;
      expected_nodes.push_back(n);
    end
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    errors++;
    $display("mismatch %s: got %h want %h", what, got, want);
  endtask

  function automatic int pick_gap();
    if ($urandom_range(0, 2) == 0) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
    return $urandom_range(0, 3);
  endfunction

  function automatic logic [295:0] pack_point(point_t p);
    logic [295:0] d;
    d = '0;
    d[17:0] = p.r;
    d[35:18] = p.s;
    for (int k = 0; k < 4; k++) begin
      d[36 + 32*k +: 32] = p.cx[k];
      d[164 + 32*k +: 32] = p.cy[k];
    end
    return d;
  endfunction

  // driver
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_tvalid || in_fire) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
          in_tvalid <= 1'b0;
        end else if (pending_pts.size() > 0) begin
          cur_pt = pending_pts.pop_front();
          in_tdata <= pack_point(cur_pt);
          in_tvalid <= 1'b1;
          in_gap <= pick_gap();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
      if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        out_gap <= pick_gap();
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    node_res_t got, want;
    in_fire = rst_n && in_tvalid && in_tready;
    if (in_fire) predict_nodes(cur_pt);
    if (rst_n && out_tvalid && out_tready) begin
      got.node = out_tdata[1:0];
      got.last = out_tlast;
      got.shape = out_tdata[18:2];
      got.dx = out_tdata[50:19];
      got.dy = out_tdata[82:51];
      got.det = out_tdata[146:83];
      got.i00 = out_tdata[178:147];
      got.i01 = out_tdata[210:179];
      got.i10 = out_tdata[242:211];
      got.i11 = out_tdata[274:243];
      got.sing = out_tdata[275];
      if (expected_nodes.size() == 0) begin
        report_mismatch("unexpected item", 64'(got.node), 64'd0);
      end else begin
        want = expected_nodes.pop_front();
        if (got.node !== want.node)
          report_mismatch("node_index", 64'(got.node), 64'(want.node));
        if (got.last !== want.last)
          report_mismatch("last_node", 64'(got.last), 64'(want.last));
        if (got.shape !== want.shape)
          report_mismatch("shape_value", 64'(got.shape), 64'(want.shape));
        if (got.dx !== want.dx) report_mismatch("deriv_x", 64'(got.dx), 64'(want.dx));
        if (got.dy !== want.dy) report_mismatch("deriv_y", 64'(got.dy), 64'(want.dy));
        if (got.det !== want.det) report_mismatch("jacobian_det", got.det, want.det);
        if (got.i00 !== want.i00) report_mismatch("inv_jac_00", 64'(got.i00), 64'(want.i00));
        if (got.i01 !== want.i01) report_mismatch("inv_jac_01", 64'(got.i01), 64'(want.i01));
        if (got.i10 !== want.i10) report_mismatch("inv_jac_10", 64'(got.i10), 64'(want.i10));
        if (got.i11 !== want.i11) report_mismatch("inv_jac_11", 64'(got.i11), 64'(want.i11));
        if (got.sing !== want.sing)
          report_mismatch("singular", 64'(got.sing), 64'(want.sing));
      end
    end
  end

  function automatic point_t unit_square(int scale, logic signed [17:0] r,
                                         logic signed [17:0] s);
    point_t p;
    p.r = r;
    p.s = s;
    p.cx = '{32'(-scale), 32'(scale), 32'(scale), 32'(-scale)};
    p.cy = '{32'(scale), 32'(scale), 32'(-scale), 32'(-scale)};
    return p;
  endfunction

  function automatic logic [31:0] rand_coord(int mode);
    case (mode)
      0: return 32'($urandom_range(0, 4 * 65536)) - 32'd131072;
      1: return $urandom;
      default: return 32'($urandom_range(0, 2047)) - 32'd1024;
    endcase
  endfunction

  initial begin
    point_t p;
    int mode;
    p = unit_square(65536, 18'sd0, 18'sd0);
    pending_pts.push_back(p);
    p = unit_square(65536, -18'sd65536, -18'sd65536);
    pending_pts.push_back(p);
    p = unit_square(65536, 18'sd65536, 18'sd65536);
    pending_pts.push_back(p);
    p = unit_square(65536, 18'sd65536, -18'sd65536);
    pending_pts.push_back(p);
    p = unit_square(1, 18'sd12345, -18'sd7);
    pending_pts.push_back(p);
    // out of range natural coordinates: extremes of the 18-bit field
    p = unit_square(65536, 18'sh1FFFF, 18'sh20000);
    pending_pts.push_back(p);
    p = unit_square(65536, 18'sh20000, 18'sh1FFFF);
    pending_pts.push_back(p);
    // degenerate element: all corners equal
    p.r = 18'sd100;
    p.s = -18'sd200;
    p.cx = '{4{32'sd70000}};
    p.cy = '{4{-32'sd5}};
    pending_pts.push_back(p);
    p.cx = '{4{32'h7FFF_FFFF}};
    p.cy = '{4{32'h8000_0000}};
    pending_pts.push_back(p);
    // collinear corners
    p.cx = '{32'sd0, 32'sd65536, 32'sd131072, 32'sd196608};
    p.cy = '{32'sd0, 32'sd65536, 32'sd131072, 32'sd196608};
    pending_pts.push_back(p);
    // coordinate extremes and saturation
    p.r = 18'sd0;
    p.s = 18'sd0;
    p.cx = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000};
    p.cy = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000};
    pending_pts.push_back(p);
    p.cx = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF};
    p.cy = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000};
    pending_pts.push_back(p);
    p = unit_square(3, 18'sd65536, 18'sd0);
    pending_pts.push_back(p);
    for (int i = 0; i < 100; i++) begin
      mode = $urandom_range(0, 2);
      if ($urandom_range(0, 4) == 0) begin
        p.r = 18'($urandom);
        p.s = 18'($urandom);
      end else begin
        p.r = 18'($urandom_range(0, 131072)) - 18'sd65536;
        p.s = 18'($urandom_range(0, 131072)) - 18'sd65536;
      end
      for (int k = 0; k < 4; k++) begin
        p.cx[k] = rand_coord(mode);
        p.cy[k] = rand_coord(mode);
      end
      pending_pts.push_back(p);
    end
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    wait (pending_pts.size() == 0 && !in_tvalid);
    wait (expected_nodes.size() == 0);
    repeat (60) @(posedge clk);
    if (errors == 0 && expected_nodes.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("FAILED: results differ");
    $finish;
  end
endmodule

// ----- sim.f -----
hw/rtl/q4sj_pkg.sv
hw/rtl/q4sj_div.sv
hw/rtl/quad4_shape_jacobian.sv
verif/tb_quad4_shape_jacobian.sv
